@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property, sampled on the rising clock edge.
`define WBHE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen on a clock edge.
`define WBHE_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define WBHE_ASSERT(label, clk, rst, prop, msg)
`define WBHE_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ hdl/wbhe_pkg.sv @@
package wbhe_pkg;

   localparam int COORD_WIDTH   = 24;
   localparam int ANGLE_WIDTH   = 16;
   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int ATAN_ENTRIES  = 24;
   // Difference takes one bit, negation one more, CORDIC gain and sqrt(2) two more.
   localparam int XY_WIDTH      = COORD_WIDTH + 4;
   localparam int TURN_WIDTH    = 32;
   localparam logic [TURN_WIDTH-1:0] HALF_TURN = {1'b1, {(TURN_WIDTH-1){1'b0}}};
   localparam logic [ANGLE_WIDTH-1:0] HALF_ANGLE = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] target_x;
      logic signed [COORD_WIDTH-1:0] target_y;
      logic signed [ANGLE_WIDTH-1:0] heading;
   } req_type;

   typedef struct packed {
      logic        [ANGLE_WIDTH-1:0] bearing;
      logic signed [ANGLE_WIDTH-1:0] heading_error;
   } rsp_type;

   // Contents of one CORDIC cell; hold freezes the vector for a target on the same row.
   typedef struct packed {
      logic                          valid;
      logic                          hold;
      logic signed [XY_WIDTH-1:0]    x;
      logic signed [XY_WIDTH-1:0]    y;
      logic        [TURN_WIDTH-1:0]  z;
      logic        [ANGLE_WIDTH-1:0] heading;
   } cell_type;

   // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
   function automatic logic [TURN_WIDTH-1:0] atan_turn(input int idx);
      logic [TURN_WIDTH-1:0] val;
      case (idx)
         0:       val = 32'd536870912;
         1:       val = 32'd316933406;
         2:       val = 32'd167458907;
         3:       val = 32'd85004756;
         4:       val = 32'd42667331;
         5:       val = 32'd21354465;
         6:       val = 32'd10679838;
         7:       val = 32'd5340245;
         8:       val = 32'd2670163;
         9:       val = 32'd1335087;
         10:      val = 32'd667544;
         11:      val = 32'd333772;
         12:      val = 32'd166886;
         13:      val = 32'd83443;
         14:      val = 32'd41722;
         15:      val = 32'd20861;
         16:      val = 32'd10430;
         17:      val = 32'd5215;
         18:      val = 32'd2608;
         19:      val = 32'd1304;
         20:      val = 32'd652;
         21:      val = 32'd326;
         22:      val = 32'd163;
         23:      val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ hdl/waypoint_bearing_heading_error.sv @@
// From start to rsp_strobe a request passes the prep register, the CORDIC cells, then the post register.
// Throughput: one transaction per cycle while busy is low; one CORDIC cell per stage, all in flight at once.
// busy is high only while reset is asserted; results cannot be held off by the receiver.
// Reset (synchronous, active high) empties the pipeline; nothing in flight is delivered.
`include "assert_macros.svh"

module waypoint_bearing_heading_error #(
   parameter int CORDIC_STAGES = wbhe_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wbhe_pkg::req_type req_data,
   output logic              rsp_strobe,
   output wbhe_pkg::rsp_type rsp_data
);
   import wbhe_pkg::*;

   localparam int NUM_CELLS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
   localparam int LATENCY   = NUM_CELLS + 2;

   logic     req_accept;
   logic     row_west;
   cell_type chain [0:NUM_CELLS];

   assign busy       = reset;
   assign req_accept = start & ~busy;

   wbhe_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_data),
      .cell_o   (chain[0])
   );

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      wbhe_cell #(
         .SHIFT (g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cell_i (chain[g]),
         .cell_o (chain[g+1])
      );
   end

   wbhe_post u_post (
      .clock      (clock),
      .reset      (reset),
      .cell_i     (chain[NUM_CELLS]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   assign row_west = (req_data.target_y == req_data.start_y)
                   && (req_data.target_x < req_data.start_x);

   `WBHE_ASSERT(a_strobe_follows_start, clock, reset,
                rsp_strobe == $past(req_accept, LATENCY),
                "result strobe out of step with accepted transactions")
   `WBHE_ASSERT(a_row_west_half, clock, reset,
                req_accept && row_west |-> ##LATENCY rsp_data.bearing == HALF_ANGLE,
                "target due west did not give half a turn")
   `WBHE_ASSERT(a_error_matches, clock, reset,
                rsp_strobe |-> rsp_data.heading_error ==
                ANGLE_WIDTH'(rsp_data.bearing - $past(req_data.heading, LATENCY)),
                "heading error not bearing minus heading")

endmodule

@@ hdl/wbhe_prep.sv @@
module wbhe_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  wbhe_pkg::req_type  req_data,
   output wbhe_pkg::cell_type cell_o
);
   import wbhe_pkg::*;

   logic signed [COORD_WIDTH:0] dx;
   logic signed [COORD_WIDTH:0] dy;
   logic                        west;
   cell_type                    cell_in;
   cell_type                    cell_ff;

   always_comb begin
      dx = {req_data.target_x[COORD_WIDTH-1], req_data.target_x}
         - {req_data.start_x[COORD_WIDTH-1], req_data.start_x};
      dy = {req_data.target_y[COORD_WIDTH-1], req_data.target_y}
         - {req_data.start_y[COORD_WIDTH-1], req_data.start_y};
      west = dx[COORD_WIDTH];
      cell_in.valid   = accept;
      // Same row: the start angle is already the answer, so freeze the cells
      cell_in.hold    = (dy == '0);
      // Fold the left half-plane over and start the angle at half a turn
      if (west) begin
         cell_in.x = -XY_WIDTH'(dx);
         cell_in.y = -XY_WIDTH'(dy);
         cell_in.z = HALF_TURN;
      end else begin
         cell_in.x = XY_WIDTH'(dx);
         cell_in.y = XY_WIDTH'(dy);
         cell_in.z = '0;
      end
      cell_in.heading = req_data.heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

@@ hdl/wbhe_cell.sv @@
module wbhe_cell #(
   parameter int SHIFT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  wbhe_pkg::cell_type cell_i,
   output wbhe_pkg::cell_type cell_o
);
   import wbhe_pkg::*;

   localparam logic [TURN_WIDTH-1:0] ATAN_STEP = atan_turn(SHIFT);

   logic signed [XY_WIDTH-1:0] x_sh;
   logic signed [XY_WIDTH-1:0] y_sh;
   cell_type                   cell_in;
   cell_type                   cell_ff;

   always_comb begin
      x_sh    = cell_i.x >>> SHIFT;
      y_sh    = cell_i.y >>> SHIFT;
      cell_in = cell_i;
      if (!cell_i.hold) begin
         // Rotate towards the x axis; both updates use the old vector
         if (!cell_i.y[XY_WIDTH-1]) begin
            cell_in.x = cell_i.x + y_sh;
            cell_in.y = cell_i.y - x_sh;
            cell_in.z = cell_i.z + ATAN_STEP;
         end else begin
            cell_in.x = cell_i.x - y_sh;
            cell_in.y = cell_i.y + x_sh;
            cell_in.z = cell_i.z - ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

@@ hdl/wbhe_post.sv @@
module wbhe_post (
   input  logic               clock,
   input  logic               reset,
   input  wbhe_pkg::cell_type cell_i,
   output logic               rsp_strobe,
   output wbhe_pkg::rsp_type  rsp_data
);
   import wbhe_pkg::*;

   localparam logic [TURN_WIDTH-1:0] ROUND_ADD =
      TURN_WIDTH'(1) << (TURN_WIDTH - 1 - ANGLE_WIDTH);

   logic [TURN_WIDTH-1:0]  z_round;
   rsp_type                rsp_data_in;
   rsp_type                rsp_data_ff;
   logic                   rsp_strobe_ff;

   always_comb begin
      // Round half up to the output angle, wrapping at a full turn
      z_round                   = cell_i.z + ROUND_ADD;
      rsp_data_in.bearing       = z_round[TURN_WIDTH-1 -: ANGLE_WIDTH];
      rsp_data_in.heading_error = rsp_data_in.bearing - cell_i.heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cell_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
